>>> src/dvrt_pkg.sv
// ----------------------------------------------------------------------------
// dvrt_pkg
// Shared types and constants of the distance-vector route table unit.
// ----------------------------------------------------------------------------
package dvrt_pkg;

    // Table geometry
    localparam int ENTRIES    = 8;
    localparam int SLOT_W     = $clog2(ENTRIES);
    localparam int NAME_WORDS = 4;
    localparam int NAME_IDX_W = $clog2(NAME_WORDS);
    localparam int WORD_W     = 64;

    // Field widths
    localparam int OP_W       = 2;
    localparam int STATUS_W   = 3;
    localparam int ADDR_W     = 32;
    localparam int PORT_W     = 16;
    localparam int HOPS_W     = 32;
    localparam int SLOT_OUT_W = 3;

    // Configuration port
    localparam int CFG_INDEX_W  = 3;
    localparam int NUM_CFG_REGS = NAME_WORDS;

    // Stream payload widths (whole bytes)
    localparam int S_TDATA_W = NAME_WORDS * WORD_W + ADDR_W + PORT_W + HOPS_W;
    localparam int M_DATA_BITS = ADDR_W + PORT_W + HOPS_W + SLOT_OUT_W;
    localparam int M_TDATA_W = ((M_DATA_BITS + 7) / 8) * 8;
    localparam int M_PAD_W   = M_TDATA_W - M_DATA_BITS;

    localparam logic [HOPS_W-1:0] HOPS_MAX  = '1;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(ENTRIES - 1);

    typedef logic [NAME_WORDS-1:0][WORD_W-1:0] name_t;
    typedef logic [SLOT_W-1:0] slot_t;

    typedef enum logic [OP_W-1:0] {
        OP_ADVERTISE = 2'd0,
        OP_LOOKUP    = 2'd1,
        OP_DELETE    = 2'd2
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_INSERTED  = 3'd0,
        STATUS_UPDATED   = 3'd1,
        STATUS_UNCHANGED = 3'd2,
        STATUS_FULL      = 3'd3,
        STATUS_FOUND     = 3'd4,
        STATUS_NOT_FOUND = 3'd5,
        STATUS_DELETED   = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE
    } state_t;

    // Entry as read from the store
    typedef struct packed {
        logic              valid;
        name_t             name;
        logic [ADDR_W-1:0] next_address;
        logic [PORT_W-1:0] next_port;
        logic [HOPS_W-1:0] hops;
    } entry_rd_t;

    // Write request into the store
    typedef struct packed {
        logic              en;
        slot_t             slot;
        logic              valid;
        logic              set_name;
        name_t             name;
        logic [ADDR_W-1:0] next_address;
        logic [PORT_W-1:0] next_port;
        logic [HOPS_W-1:0] hops;
    } entry_wr_t;

    // Compare unit verdict
    typedef struct packed {
        logic match;
        logic better;
    } cmp_t;

endpackage

>>> src/dvrt_entry_store.sv
// ----------------------------------------------------------------------------
// dvrt_entry_store
// Route entry storage: payload memories with a registered read port, valid
// flip-flops and the own-name registers that back slot 0.
// ----------------------------------------------------------------------------
module dvrt_entry_store (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [dvrt_pkg::CFG_INDEX_W-1:0] cfg_wr_index,
    input  logic [dvrt_pkg::WORD_W-1:0]   cfg_wr_data,
    input  dvrt_pkg::slot_t               rd_slot,
    output dvrt_pkg::entry_rd_t           rd_entry,
    input  dvrt_pkg::entry_wr_t           wr
);
    import dvrt_pkg::*;

    name_t             name_mem [ENTRIES];
    logic [ADDR_W-1:0] addr_mem [ENTRIES];
    logic [PORT_W-1:0] port_mem [ENTRIES];
    logic [HOPS_W-1:0] hops_mem [ENTRIES];

    logic [ENTRIES-1:0] valid_reg;
    name_t              own_name_reg;
    logic               slot0_own_reg;

    name_t              rd_name_q;
    logic [ADDR_W-1:0]  rd_addr_q;
    logic [PORT_W-1:0]  rd_port_q;
    logic [HOPS_W-1:0]  rd_hops_q;
    logic               rd_valid_q;
    logic               rd_own_q;

    logic cfg_hit;
    assign cfg_hit = cfg_wr_en && (cfg_wr_index < CFG_INDEX_W'(NUM_CFG_REGS));

    // Own name and slot 0 reload; slot 0 reads from the own name until an
    // insert overwrites it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_name_reg  <= '0;
            slot0_own_reg <= 1'b1;
        end else if (cfg_hit) begin
            own_name_reg[cfg_wr_index[NAME_IDX_W-1:0]] <= cfg_wr_data;
            slot0_own_reg <= 1'b1;
        end else if (wr.en && wr.set_name && (wr.slot == '0)) begin
            slot0_own_reg <= 1'b0;
        end
    end

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= ENTRIES'(1);
        end else if (cfg_hit) begin
            valid_reg[0] <= 1'b1;
        end else if (wr.en) begin
            valid_reg[wr.slot] <= wr.valid;
        end
    end

    // Payload write
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            if (wr.set_name) begin
                name_mem[wr.slot] <= wr.name;
            end
            addr_mem[wr.slot] <= wr.next_address;
            port_mem[wr.slot] <= wr.next_port;
            hops_mem[wr.slot] <= wr.hops;
        end
    end

    // Registered read
    always_ff @(posedge aclk) begin
        rd_name_q  <= name_mem[rd_slot];
        rd_addr_q  <= addr_mem[rd_slot];
        rd_port_q  <= port_mem[rd_slot];
        rd_hops_q  <= hops_mem[rd_slot];
        rd_valid_q <= valid_reg[rd_slot];
        rd_own_q   <= slot0_own_reg && (rd_slot == '0);
    end

    // Slot 0 holding the own name carries a zero next hop
    always_comb begin
        rd_entry.valid = rd_valid_q;
        if (rd_own_q) begin
            rd_entry.name         = own_name_reg;
            rd_entry.next_address = '0;
            rd_entry.next_port    = '0;
            rd_entry.hops         = '0;
        end else begin
            rd_entry.name         = rd_name_q;
            rd_entry.next_address = rd_addr_q;
            rd_entry.next_port    = rd_port_q;
            rd_entry.hops         = rd_hops_q;
        end
    end

endmodule

>>> src/dvrt_compare_unit.sv
// ----------------------------------------------------------------------------
// dvrt_compare_unit
// Shared compare unit: name match against one entry per cycle, saturating
// hop increment and the shorter-route test.
// ----------------------------------------------------------------------------
module dvrt_compare_unit (
    input  dvrt_pkg::name_t               key_name,
    input  logic [dvrt_pkg::HOPS_W-1:0]   adv_hops,
    input  dvrt_pkg::entry_rd_t           entry,
    output logic [dvrt_pkg::HOPS_W-1:0]   hops_inc,
    output dvrt_pkg::cmp_t                verdict
);
    import dvrt_pkg::*;

    // Saturate the incremented hop count
    assign hops_inc = (adv_hops == HOPS_MAX) ? HOPS_MAX : adv_hops + HOPS_W'(1);

    // Only valid entries match; better means the stored route is longer
    assign verdict.match  = entry.valid && (entry.name == key_name);
    assign verdict.better = entry.hops > hops_inc;

endmodule

>>> src/distance_vector_route_table_unit.sv
// ----------------------------------------------------------------------------
// distance_vector_route_table_unit
// Distance-vector route table: advertise, lookup and delete by 32-byte name.
//
//   channel  dir  handshake          payload
//   s_       in   s_tvalid/s_tready  s_tuser op, s_tdata name + next hop + hops
//   m_       out  m_tvalid/m_tready  m_tuser status, m_tdata entry + slot
//   cfg_     in   cfg_wr_en          cfg_wr_index, cfg_wr_data (own name words)
//
// An item runs from its input transfer through the scan and decide states to
// the next input transfer; its result is loaded when it leaves decide: the
// shared compare unit checks one slot per cycle behind the store's registered
// read, stops at the first match, and the decide state writes the entry back.
// Reset clears the valid bits except slot 0, which holds the own name.
// A stalled result holds the decide cycle; no item is taken until it leaves.
// ----------------------------------------------------------------------------
module distance_vector_route_table_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    // name_word_0..3, adv_next_address, adv_next_port, adv_hops
    input  logic [dvrt_pkg::S_TDATA_W-1:0]    s_tdata,
    // op
    input  logic [dvrt_pkg::OP_W-1:0]         s_tuser,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // next_address_out, next_port_out, hops_out, slot_out, zero pad
    output logic [dvrt_pkg::M_TDATA_W-1:0]    m_tdata,
    // status
    output logic [dvrt_pkg::STATUS_W-1:0]     m_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic                              cfg_wr_en,
    input  logic [dvrt_pkg::CFG_INDEX_W-1:0]  cfg_wr_index,
    input  logic [dvrt_pkg::WORD_W-1:0]       cfg_wr_data
);
    import dvrt_pkg::*;

    localparam int NAME_BITS = NAME_WORDS * WORD_W;

    state_t state_reg, state_next;

    // Captured item
    op_t               op_reg;
    name_t             key_reg;
    logic [ADDR_W-1:0] adv_addr_reg;
    logic [PORT_W-1:0] adv_port_reg;
    logic [HOPS_W-1:0] adv_hops_reg;

    // Scan results
    slot_t             cur_slot_reg;
    logic              hit_reg;
    slot_t             hit_slot_reg;
    logic              hit_better_reg;
    logic [ADDR_W-1:0] hit_addr_reg;
    logic [PORT_W-1:0] hit_port_reg;
    logic [HOPS_W-1:0] hit_hops_reg;
    logic              free_found_reg;
    slot_t             free_slot_reg;

    // Output register
    logic              m_tvalid_reg;
    status_t           m_status_reg;
    logic [ADDR_W-1:0] m_addr_reg;
    logic [PORT_W-1:0] m_port_reg;
    logic [HOPS_W-1:0] m_hops_reg;
    logic [SLOT_OUT_W-1:0] m_slot_reg;

    slot_t             rd_slot;
    entry_rd_t         rd_entry;
    entry_wr_t         wr;
    cmp_t              verdict;
    logic [HOPS_W-1:0] hops_inc;

    logic              accept;
    logic              out_free;
    logic              last_slot;
    logic              scan_step;
    logic              out_load;
    logic              wr_want;
    status_t           res_status;
    logic [ADDR_W-1:0] res_addr;
    logic [PORT_W-1:0] res_port;
    logic [HOPS_W-1:0] res_hops;
    slot_t             res_slot;

    dvrt_entry_store u_store (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .rd_slot      (rd_slot),
        .rd_entry     (rd_entry),
        .wr           (wr)
    );

    dvrt_compare_unit u_cmp (
        .key_name (key_reg),
        .adv_hops (adv_hops_reg),
        .entry    (rd_entry),
        .hops_inc (hops_inc),
        .verdict  (verdict)
    );

    assign accept    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign last_slot = (cur_slot_reg == LAST_SLOT);

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state, read address and decision
    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        rd_slot    = '0;
        scan_step  = 1'b0;
        out_load   = 1'b0;
        wr_want    = 1'b0;
        res_status = STATUS_NOT_FOUND;
        res_addr   = '0;
        res_port   = '0;
        res_hops   = '0;
        res_slot   = '0;
        wr.en           = 1'b0;
        wr.slot         = hit_slot_reg;
        wr.valid        = 1'b1;
        wr.set_name     = 1'b0;
        wr.name         = key_reg;
        wr.next_address = adv_addr_reg;
        wr.next_port    = adv_port_reg;
        wr.hops         = hops_inc;

        // Result of the finished scan
        case (op_reg)
            OP_ADVERTISE: begin
                if (hit_reg) begin
                    res_slot = hit_slot_reg;
                    if (hit_better_reg) begin
                        wr_want    = 1'b1;
                        res_status = STATUS_UPDATED;
                        res_addr   = adv_addr_reg;
                        res_port   = adv_port_reg;
                        res_hops   = hops_inc;
                    end else begin
                        res_status = STATUS_UNCHANGED;
                        res_addr   = hit_addr_reg;
                        res_port   = hit_port_reg;
                        res_hops   = hit_hops_reg;
                    end
                end else if (free_found_reg) begin
                    wr_want     = 1'b1;
                    wr.slot     = free_slot_reg;
                    wr.set_name = 1'b1;
                    res_status  = STATUS_INSERTED;
                    res_addr    = adv_addr_reg;
                    res_port    = adv_port_reg;
                    res_hops    = hops_inc;
                    res_slot    = free_slot_reg;
                end else begin
                    res_status = STATUS_FULL;
                end
            end
            OP_LOOKUP: begin
                if (hit_reg) begin
                    res_status = STATUS_FOUND;
                    res_addr   = hit_addr_reg;
                    res_port   = hit_port_reg;
                    res_hops   = hit_hops_reg;
                    res_slot   = hit_slot_reg;
                end
            end
            OP_DELETE: begin
                if (hit_reg) begin
                    wr_want         = 1'b1;
                    wr.valid        = 1'b0;
                    wr.next_address = '0;
                    wr.next_port    = '0;
                    wr.hops         = '0;
                    res_status      = STATUS_DELETED;
                    res_addr        = hit_addr_reg;
                    res_port        = hit_port_reg;
                    res_hops        = hit_hops_reg;
                    res_slot        = hit_slot_reg;
                end
            end
            default: begin
                res_status = STATUS_NOT_FOUND;
            end
        endcase

        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                scan_step = 1'b1;
                rd_slot   = cur_slot_reg + SLOT_W'(1);
                if (verdict.match || last_slot) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    wr.en      = wr_want;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Capture item and track the scan
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            cur_slot_reg   <= '0;
        end else if (accept) begin
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            cur_slot_reg   <= '0;
        end else if (scan_step) begin
            cur_slot_reg <= cur_slot_reg + SLOT_W'(1);
            if (verdict.match) begin
                hit_reg <= 1'b1;
            end
            if (!rd_entry.valid && !free_found_reg) begin
                free_found_reg <= 1'b1;
            end
        end
    end

    // Payload of the captured item and of the scan
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg       <= op_t'(s_tuser);
            key_reg      <= name_t'(s_tdata[NAME_BITS-1:0]);
            adv_addr_reg <= s_tdata[NAME_BITS +: ADDR_W];
            adv_port_reg <= s_tdata[NAME_BITS + ADDR_W +: PORT_W];
            adv_hops_reg <= s_tdata[NAME_BITS + ADDR_W + PORT_W +: HOPS_W];
        end
        if (scan_step) begin
            if (verdict.match) begin
                hit_slot_reg   <= cur_slot_reg;
                hit_better_reg <= verdict.better;
                hit_addr_reg   <= rd_entry.next_address;
                hit_port_reg   <= rd_entry.next_port;
                hit_hops_reg   <= rd_entry.hops;
            end
            if (!rd_entry.valid && !free_found_reg) begin
                free_slot_reg <= cur_slot_reg;
            end
        end
    end

    // Output register: load on decide, drop on transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_status_reg <= res_status;
            m_addr_reg   <= res_addr;
            m_port_reg   <= res_port;
            m_hops_reg   <= res_hops;
            m_slot_reg   <= SLOT_OUT_W'(res_slot);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, m_slot_reg, m_hops_reg, m_port_reg, m_addr_reg};

`ifndef ASSERT_OFF
    // A transfer always starts a scan at slot 0
    a_accept_starts_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == ST_SCAN) && (cur_slot_reg == '0))
        else $error("scan did not start at slot 0 after input transfer");

    // The scan counter never runs past the last slot
    a_scan_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (cur_slot_reg <= LAST_SLOT))
        else $error("scan slot out of range");

    // A result appears only out of the decide cycle
    a_result_from_decide: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_DECIDE))
        else $error("result loaded outside decide");

    // Ready drops only because an item was taken
    a_ready_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_tready) |-> $past(s_tvalid))
        else $error("ready dropped without an input transfer");

    // A table write happens only in the decide state, after a scan
    a_no_write_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        wr.en |-> (state_reg == ST_DECIDE) && $past(state_reg != ST_IDLE))
        else $error("table write outside a finished scan");
`endif

endmodule
